>>> hw/rtl/utf8d_pkg.sv
// Package for the UTF-8 stream decoder.
// Holds the result item type, decoding constants and the byte-merge helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

    localparam int unsigned CpWidth = 21;

    localparam logic [CpWidth-1:0] SUBST_CP = 21'd63;   // '?'

    // One result item
    typedef struct packed {
        logic [CpWidth-1:0] cp;
        logic               eot;
        logic               last;
    } res_t;

    // Sequence length announced by a lead byte: 1..4, or 0 for a bad lead
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] n;
        if (b[7] == 1'b0)
            n = 3'd1;
        else if ((b & 8'hE0) == 8'hC0)
            n = 3'd2;
        else if ((b & 8'hF0) == 8'hE0)
            n = 3'd3;
        else if ((b & 8'hF8) == 8'hF0)
            n = 3'd4;
        else
            n = 3'd0;
        return n;
    endfunction

    // Merge n bytes (1..4) into one code point; followers give their low six bits
    function automatic logic [CpWidth-1:0] merge(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic [2:0] n
    );
        logic [CpWidth-1:0] c;
        case (n)
            3'd2:    c = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    c = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            3'd4:    c = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default: c = {13'd0, b0};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/utf8_stream_decoder_core.sv
// UTF-8 stream decoder top level: one byte in, code points out.
// Depends on utf8d_pkg for the result type and the decoding helpers.
`timescale 1ns / 1ps
`default_nettype none

// Takes a NUL-terminated text on the s_ side and gives one code point per
// complete character on the m_ side; a byte below 0x80 outside a sequence
// passes through, bad leads give '?' (63), and NUL gives an end-of-text item
// (tuser high, code point zero). Every item that leads to at most one result
// is taken without a stall, so the sustained rate is one byte per clock while
// the output is not held; the output register with a one-entry skid stage
// keeps s_tready registered. A NUL that cuts a multi-byte sequence short
// starts a replay of the held bytes: a small sequencer then gives one result
// per cycle while the output is free ('?' for the lead, re-decoded followers,
// end of text), and s_tready stays low until the replay ends.
module utf8_stream_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    // decoded results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [20:0] code_point, [23:21] zero
    output logic             m_tuser,   // [0] end_of_text
    output logic             m_tlast    // last_of_run
);
    import utf8d_pkg::*;

    // Decoder state
    logic [7:0] held0_reg, held1_reg, held2_reg;
    logic [7:0] held0_next, held1_next, held2_next;
    logic [1:0] held_cnt_reg, held_cnt_next;
    logic [2:0] need_cnt_reg, need_cnt_next;

    // Replay sequencer
    logic       rp_active_reg, rp_active_next;
    logic [1:0] rp_pos_reg, rp_pos_next;
    logic [1:0] rp_len_reg, rp_len_next;

    // Output register and skid
    res_t out_reg, out_next;
    res_t skid_reg, skid_next;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;

    logic       acc;
    logic       push;
    res_t       push_res;
    logic [2:0] in_len;
    logic [7:0] m0, m1, m2;
    logic [7:0] rp_lead, rp_f1, rp_f2;
    logic [2:0] rp_n;
    logic [1:0] rp_rem;
    logic       out_free;

    assign s_tready = !skid_valid_reg && !rp_active_reg;
    assign acc      = s_tvalid && s_tready;
    assign in_len   = seq_len(s_tdata);
    assign out_free = !out_valid_reg || m_tready;

    // Bytes of a sequence completed by the incoming byte
    assign m0 = (held_cnt_reg == 2'd0) ? s_tdata : held0_reg;
    assign m1 = (held_cnt_reg == 2'd1) ? s_tdata : held1_reg;
    assign m2 = (held_cnt_reg == 2'd2) ? s_tdata : held2_reg;

    // Replay selection at the current position
    always_comb
    begin
        case (rp_pos_reg)
            2'd1:
            begin
                rp_lead = held1_reg;
                rp_f1   = held2_reg;
                rp_f2   = 8'd0;
            end
            2'd2:
            begin
                rp_lead = held2_reg;
                rp_f1   = 8'd0;
                rp_f2   = 8'd0;
            end
            default:
            begin
                rp_lead = held0_reg;
                rp_f1   = held1_reg;
                rp_f2   = held2_reg;
            end
        endcase
    end

    assign rp_n   = seq_len(rp_lead);
    assign rp_rem = rp_len_reg - rp_pos_reg;

    // Decode and replay step
    always_comb
    begin
        held0_next     = held0_reg;
        held1_next     = held1_reg;
        held2_next     = held2_reg;
        held_cnt_next  = held_cnt_reg;
        need_cnt_next  = need_cnt_reg;
        rp_active_next = rp_active_reg;
        rp_pos_next    = rp_pos_reg;
        rp_len_next    = rp_len_reg;
        push           = 1'b0;
        push_res       = '{cp: '0, eot: 1'b0, last: 1'b1};

        if (rp_active_reg)
        begin
            if (!skid_valid_reg)
            begin
                push = 1'b1;
                if (rp_pos_reg < rp_len_reg)
                begin
                    push_res.last = 1'b0;
                    if (rp_n != 3'd0 && rp_n <= {1'b0, rp_rem})
                    begin
                        push_res.cp = merge(rp_lead, rp_f1, rp_f2, 8'd0, rp_n);
                        rp_pos_next = rp_pos_reg + rp_n[1:0];
                    end
                    else
                    begin
                        push_res.cp = SUBST_CP;
                        rp_pos_next = rp_pos_reg + 2'd1;
                    end
                end
                else
                begin
                    // end of text closes the replay
                    push_res.eot   = 1'b1;
                    rp_active_next = 1'b0;
                end
            end
        end
        else if (acc)
        begin
            if (s_tdata == 8'd0)
            begin
                held_cnt_next = 2'd0;
                need_cnt_next = 3'd0;
                if (held_cnt_reg == 2'd0)
                begin
                    push         = 1'b1;
                    push_res.eot = 1'b1;
                end
                else
                begin
                    rp_active_next = 1'b1;
                    rp_pos_next    = 2'd0;
                    rp_len_next    = held_cnt_reg;
                end
            end
            else if (need_cnt_reg == 3'd0)
            begin
                if (in_len == 3'd1)
                begin
                    push        = 1'b1;
                    push_res.cp = {13'd0, s_tdata};
                end
                else if (in_len == 3'd0)
                begin
                    push        = 1'b1;
                    push_res.cp = SUBST_CP;
                end
                else
                begin
                    held0_next    = s_tdata;
                    held_cnt_next = 2'd1;
                    need_cnt_next = in_len;
                end
            end
            else if (({1'b0, held_cnt_reg} + 3'd1) >= need_cnt_reg || held_cnt_reg == 2'd3)
            begin
                push          = 1'b1;
                push_res.cp   = merge(m0, m1, m2, s_tdata, {1'b0, held_cnt_reg} + 3'd1);
                held_cnt_next = 2'd0;
                need_cnt_next = 3'd0;
            end
            else
            begin
                case (held_cnt_reg)
                    2'd0:    held0_next = s_tdata;
                    2'd1:    held1_next = s_tdata;
                    default: held2_next = s_tdata;
                endcase
                held_cnt_next = held_cnt_reg + 2'd1;
            end
        end
    end

    // Output register with skid entry
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_next       = push_res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_next       = push_res;
            skid_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg   <= 2'd0;
            need_cnt_reg   <= 3'd0;
            rp_active_reg  <= 1'b0;
            rp_pos_reg     <= 2'd0;
            rp_len_reg     <= 2'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            held_cnt_reg   <= held_cnt_next;
            need_cnt_reg   <= need_cnt_next;
            rp_active_reg  <= rp_active_next;
            rp_pos_reg     <= rp_pos_next;
            rp_len_reg     <= rp_len_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
        held2_reg <= held2_next;
        out_reg   <= out_next;
        skid_reg  <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_reg.cp};
    assign m_tuser  = out_reg.eot;
    assign m_tlast  = out_reg.last;

endmodule

`default_nettype wire

>>> bench/utf8_decode_checker.sv
// Checker for the UTF-8 stream decoder: watches both streams, predicts the
// code points of every accepted byte and compares them with the output items.
// Depends on utf8d_pkg for the result item type and the code point width.
`timescale 1ns / 1ps

module utf8_decode_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // [20:0] code_point, [23:21] zero
    input  logic        m_tuser,    // [0] end_of_text
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    import utf8d_pkg::*;

    localparam int MaxPrinted = 20;

    // predictor state: bytes of an unfinished sequence
    logic [7:0] seq_bytes [0:2];
    int         seq_held;
    int         seq_want;

    res_t       cp_expected [$];
    int         fails = 0;
    int         waiting = 0;

    assign fail_count = fails;
    assign pending    = waiting;

    task automatic report_mismatch(input string msg);
        if (fails < MaxPrinted)
            $display("[%0t] mismatch: %s", $realtime, msg);
        fails++;
    endtask

    // sequence length from the lead byte, 0 for a lead that cannot start one
    function automatic int lead_length(input logic [7:0] b);
        int n;
        casez (b)
            8'b0???????: n = 1;
            8'b110?????: n = 2;
            8'b1110????: n = 3;
            8'b11110???: n = 4;
            default:     n = 0;
        endcase
        return n;
    endfunction

    // join n bytes (byte i at bits 8*i) into one code point
    function automatic logic [CpWidth-1:0] join_bytes(input logic [31:0] bytes, input int n);
        logic [31:0] acc;
        int i;
        if (n == 1)
            return {{(CpWidth-8){1'b0}}, bytes[7:0]};
        acc = {24'd0, bytes[7:0] & (8'h7F >> n)};
        for (i = 1; i < n; i++)
            acc = (acc << 6) | {26'd0, bytes[8*i +: 6]};
        return acc[CpWidth-1:0];
    endfunction

    // work out the results one input byte causes and queue them
    task automatic decode_byte(input logic [7:0] b);
        res_t        produced [$];
        res_t        r;
        logic [31:0] bytes;
        int          pos;
        int          n;
        int          i;
        r = '0;
        if (b == 8'h00) begin
            // replay whatever is held, then the end-of-text item
            pos = 0;
            while (pos < seq_held) begin
                n = lead_length(seq_bytes[pos]);
                r = '0;
                if (n != 0 && n <= seq_held - pos) begin
                    bytes = '0;
                    for (i = 0; i < n; i++)
                        bytes[8*i +: 8] = seq_bytes[pos + i];
                    r.cp = join_bytes(bytes, n);
                    pos += n;
                end
                else begin
                    r.cp = SUBST_CP;
                    pos += 1;
                end
                produced.push_back(r);
            end
            r = '0;
            r.eot = 1'b1;
            produced.push_back(r);
            seq_held = 0;
            seq_want = 0;
        end
        else if (seq_want == 0) begin
            n = lead_length(b);
            if (n == 1) begin
                r.cp = {{(CpWidth-8){1'b0}}, b};
                produced.push_back(r);
            end
            else if (n == 0) begin
                r.cp = SUBST_CP;
                produced.push_back(r);
            end
            else begin
                seq_bytes[0] = b;
                seq_held     = 1;
                seq_want     = n;
            end
        end
        else if (seq_held + 1 >= seq_want) begin
            // follower completes the sequence
            bytes = '0;
            for (i = 0; i < seq_held; i++)
                bytes[8*i +: 8] = seq_bytes[i];
            bytes[8*seq_held +: 8] = b;
            r.cp = join_bytes(bytes, seq_held + 1);
            produced.push_back(r);
            seq_held = 0;
            seq_want = 0;
        end
        else begin
            seq_bytes[seq_held] = b;
            seq_held++;
        end
        if (produced.size() > 0)
            produced[produced.size() - 1].last = 1'b1;
        foreach (produced[k])
            cp_expected.push_back(produced[k]);
    endtask

    // predict on accepted input items, compare accepted output items
    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t e;
        if (!rst_n) begin
            seq_held = 0;
            seq_want = 0;
            cp_expected.delete();
            waiting = 0;
        end
        else begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (cp_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected item cp=%h eot=%b last=%b",
                                              m_tdata[20:0], m_tuser, m_tlast));
                end
                else begin
                    e = cp_expected.pop_front();
                    if (m_tdata[20:0] !== e.cp)
                        report_mismatch($sformatf("code_point %h, expected %h",
                                                  m_tdata[20:0], e.cp));
                    if (m_tdata[23:21] !== 3'b000)
                        report_mismatch($sformatf("tdata pad bits %b", m_tdata[23:21]));
                    if (m_tuser !== e.eot)
                        report_mismatch($sformatf("end_of_text %b, expected %b",
                                                  m_tuser, e.eot));
                    if (m_tlast !== e.last)
                        report_mismatch($sformatf("last_of_run %b, expected %b (cp %h)",
                                                  m_tlast, e.last, e.cp));
                end
            end
            waiting = cp_expected.size();
        end
    end

endmodule

>>> bench/testbench.sv
// Top of the UTF-8 stream decoder bench: clock, reset, byte stimulus and
// output back-pressure; the checker does prediction and comparison.
// Depends on utf8_stream_decoder_core, utf8_decode_checker and utf8d_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam logic [7:0] NUL_BYTE    = 8'h00;
    localparam int         RandomItems = 136;
    localparam int         OpeningLen  = 24;
    localparam int         QuietFrom   = OpeningLen + 110;
    localparam int         HoldAt      = OpeningLen + 60;
    localparam int         HoldCycles  = 64;
    localparam int         SettleCycles = 16;
    localparam int         StallLimit  = 1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;    // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [20:0] code_point, [23:21] zero
    logic        m_tuser;            // [0] end_of_text
    logic        m_tlast;

    int          fail_count;
    int          pending;
    int          sent_n = 0;
    bit          quiet = 1'b0;       // no idling on either side
    bit          long_hold = 1'b0;   // asks the receiver for a long hold-off

    utf8_stream_decoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    utf8_decode_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // offer one byte, with an occasional gap first, and wait until taken
    task automatic push_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sent_n++;
        if (sent_n == HoldAt)
            long_hold = 1'b1;
        if (sent_n == QuietFrom)
            quiet = 1'b1;
    endtask

    // stop sending until every predicted result has come out
    task automatic drain;
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // one random piece of text: mostly whole characters, some cut or noise
    task automatic random_piece;
        int          kind;
        int          len;
        logic [7:0]  lead;
        logic [7:0]  follow;
        kind = $urandom_range(0, 9);
        len  = $urandom_range(1, 4);
        case (len)
            1:       lead = 8'($urandom_range(1, 127));
            2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
            3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
            default: lead = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        if (kind <= 5) begin
            // well-formed character, followers with the odd bad tag
            push_byte(lead);
            repeat (len - 1) begin
                if ($urandom_range(0, 5) == 0)
                    follow = 8'($urandom_range(1, 255));
                else
                    follow = 8'h80 | 8'($urandom_range(0, 63));
                push_byte(follow);
            end
        end
        else if (kind == 6) begin
            // sequence cut short by the terminator, any nonzero followers
            if (len == 1)
                lead = 8'hF0 | 8'($urandom_range(0, 7));
            push_byte(lead);
            repeat ($urandom_range(0, (len == 1 ? 4 : len) - 2))
                push_byte(8'($urandom_range(1, 255)));
            push_byte(NUL_BYTE);
        end
        else if (kind == 7) begin
            push_byte(NUL_BYTE);
        end
        else begin
            push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: too long with no item accepted on either side
    initial
    begin
        int still = 0;
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                still = 0;
            else
                still++;
            if (still >= StallLimit) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [7:0] opening [OpeningLen] = '{
            8'h41, 8'h80, 8'hFF, 8'hF8,            // ASCII, bad leads
            8'hC3, 8'hA9,                          // two-byte
            8'hE2, 8'h82, 8'hAC,                   // three-byte
            8'hF7, 8'hBF, 8'hBF, 8'hBF,            // four-byte, largest code point
            8'hC0, 8'h41,                          // overlong, follower tag unchecked
            8'h00,                                 // terminator with nothing held
            8'hF0, 8'hC3, 8'hA9, 8'h00,            // cut: lead '?', held pair merges
            8'hF0, 8'h41, 8'hE2, 8'h00             // cut: '?', 'A', '?', end
        };
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            push_byte(opening[i]);
        drain();

        while (sent_n < OpeningLen + RandomItems) begin
            random_piece();
            if (sent_n >= OpeningLen + 100 && sent_n < OpeningLen + 105)
                drain();
        end
        push_byte(NUL_BYTE);

        drain();
        repeat (SettleCycles) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/utf8d_pkg.sv
hw/rtl/utf8_stream_decoder_core.sv
bench/utf8_decode_checker.sv
bench/testbench.sv
